// File: hw/rtl/frc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the frame receiver.
package frc_pkg;

    localparam logic [7:0]  START_BYTE     = 8'h01;
    localparam logic [7:0]  KIND_NONE      = 8'd0;
    localparam logic [7:0]  KIND_CRC32     = 8'd32;
    localparam logic [1:0]  LENGTH_LAST    = 2'd1;   // two length bytes
    localparam logic [1:0]  CHECK_LAST     = 2'd3;   // four checksum bytes
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET     = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_FINAL_XOR  = 32'hFFFFFFFF;
    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_KIND    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_HDRXOR  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_GOOD = 3'd1,
        EV_ZERO = 3'd2,
        EV_XOR  = 3'd3,
        EV_LONG = 3'd4,
        EV_CRC  = 3'd5
    } event_t;

    typedef struct packed {
        logic init;
        logic step;
    } crc_ctrl_t;

    typedef struct packed {
        logic        byte_invalid;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        event_t      frame_event;
        logic [15:0] frame_length;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/frc_crc.sv
// Running CRC-32 register over payload words.
module frc_crc (
    input  logic             clk,
    input  logic             rst_n,
    input  frc_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]       data,
    output logic [31:0]      crc
);
    import frc_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.init)
            crc_next = CRC_PRESET;
        else if (ctrl.step)
            crc_next = crc_byte(crc_reg, data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= '0;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

// File: hw/rtl/frc_deframer.sv
// Frame phase sequencer: header parsing, payload pass-through and verdict.
module frc_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  logic [15:0]        capacity,
    input  logic [31:0]        crc,
    output frc_pkg::crc_ctrl_t crc_ctrl,
    output frc_pkg::result_t   result
);
    import frc_pkg::*;

    phase_t      phase_reg,   phase_next;
    logic        kind_none_reg, kind_none_next;
    logic        kind_crc_reg,  kind_crc_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] count_reg,   count_next;
    logic [23:0] acc_reg,     acc_next;
    logic [1:0]  fcnt_reg,    fcnt_next;
    logic [7:0]  hxor_reg,    hxor_next;

    logic [15:0] count_inc;
    logic [15:0] length_full;
    logic        clear;

    assign count_inc   = count_reg + 16'd1;
    assign length_full = {rx_byte, length_reg[7:0]};

    always_comb
    begin
        phase_next     = phase_reg;
        kind_none_next = kind_none_reg;
        kind_crc_next  = kind_crc_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        fcnt_next      = fcnt_reg;
        hxor_next      = hxor_reg;
        clear          = 1'b0;
        crc_ctrl       = '0;
        result         = '0;
        result.frame_event = EV_NONE;

        unique case (phase_reg)
            PH_KIND:
            begin
                kind_none_next = (rx_byte == KIND_NONE);
                kind_crc_next  = (rx_byte == KIND_CRC32);
                hxor_next      = hxor_reg ^ rx_byte;
                fcnt_next      = '0;
                phase_next     = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                hxor_next = hxor_reg ^ rx_byte;
                if (fcnt_reg == LENGTH_LAST)
                begin
                    length_next = length_full;
                    if (length_full == 16'd0)
                    begin
                        result.frame_event = EV_ZERO;
                        clear = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HDRXOR;
                    end
                end
                else
                begin
                    length_next = {8'd0, rx_byte};
                    fcnt_next   = fcnt_reg + 2'd1;
                end
            end
            PH_HDRXOR:
            begin
                if (hxor_reg != rx_byte)
                begin
                    result.frame_event  = EV_XOR;
                    result.frame_length = length_reg;
                    clear = 1'b1;
                end
                else if (length_reg > capacity)
                begin
                    result.frame_event  = EV_LONG;
                    result.frame_length = length_reg;
                    clear = 1'b1;
                end
                else
                begin
                    phase_next    = PH_PAYLOAD;
                    crc_ctrl.init = kind_crc_reg;
                end
            end
            PH_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                crc_ctrl.step        = 1'b1;
                count_next           = count_inc;
                if (count_inc == length_reg)
                begin
                    if (!kind_none_reg)
                    begin
                        phase_next = PH_CHECK;
                        acc_next   = '0;
                        fcnt_next  = '0;
                    end
                    else
                    begin
                        result.frame_event  = EV_GOOD;
                        result.frame_length = length_reg;
                        clear = 1'b1;
                    end
                end
            end
            PH_CHECK:
            begin
                case (fcnt_reg)
                    2'd0:    acc_next[7:0]   = rx_byte;
                    2'd1:    acc_next[15:8]  = rx_byte;
                    default: acc_next[23:16] = rx_byte;
                endcase
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == CHECK_LAST)
                begin
                    if (kind_crc_reg && ((crc ^ CRC_FINAL_XOR) != {rx_byte, acc_reg}))
                        result.frame_event = EV_CRC;
                    else
                        result.frame_event = EV_GOOD;
                    result.frame_length = length_reg;
                    clear = 1'b1;
                end
            end
            default:
            begin
                clear = 1'b1;
                if (rx_byte == START_BYTE)
                    phase_next = PH_KIND;
                else
                    result.byte_invalid = 1'b1;
            end
        endcase

        if (clear)
        begin
            if (!(phase_reg == PH_IDLE && rx_byte == START_BYTE) &&
                !(phase_reg != PH_KIND && phase_reg != PH_LENGTH && phase_reg != PH_HDRXOR &&
                  phase_reg != PH_PAYLOAD && phase_reg != PH_CHECK && rx_byte == START_BYTE))
                phase_next = PH_IDLE;
            kind_none_next = 1'b1;
            kind_crc_next  = 1'b0;
            length_next    = '0;
            count_next     = '0;
            acc_next       = '0;
            fcnt_next      = '0;
            hxor_next      = (phase_next == PH_KIND) ? rx_byte : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            kind_none_reg <= 1'b1;
            kind_crc_reg  <= 1'b0;
            length_reg    <= '0;
            count_reg     <= '0;
            acc_reg       <= '0;
            fcnt_reg      <= '0;
            hxor_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            kind_none_reg <= kind_none_next;
            kind_crc_reg  <= kind_crc_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            fcnt_reg      <= fcnt_next;
            hxor_reg      <= hxor_next;
        end
    end

endmodule

// File: hw/rtl/frc_out_reg.sv
// Result register with valid/ready hand-off to the output channel.
module frc_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  frc_pkg::result_t result_in,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             free,
    output frc_pkg::result_t result_out
);
    import frc_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

// File: hw/rtl/frame_receiver_crc32.sv
// Top level of the byte-serial frame receiver with CRC-32 check.
//
//  channel   signals                          direction  notes
//  in        in_valid, in_ready, rx_byte      sink       one link byte per word
//  out       out_valid, out_ready, fields     source     one result word per input word
//  cfg       cfg_wr_en, cfg_wr_data           sink       buffer capacity, no wait
//
//  One word per cycle while in_ready is high; each result is registered when taken.
//  Each word is parsed, and a payload word CRC-updated, in the cycle it is taken.
//  in_ready is high whenever the result register is empty or being emptied.
//  A stalled output holds its result and blocks input only while full.
//  Reset returns the parser to idle and the capacity to 1024.
module frame_receiver_crc32 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_invalid,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [2:0]  frame_event,
    output logic [15:0] frame_length,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import frc_pkg::*;

    logic        accept;
    logic [15:0] capacity_reg;
    logic [31:0] crc;
    crc_ctrl_t   crc_ctrl;
    result_t     result_comb;
    result_t     result_q;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RESET;
        else if (cfg_wr_en)
            capacity_reg <= cfg_wr_data;
    end

    frc_deframer u_deframer (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .capacity (capacity_reg),
        .crc      (crc),
        .crc_ctrl (crc_ctrl),
        .result   (result_comb)
    );

    frc_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (accept ? crc_ctrl : crc_ctrl_t'('0)),
        .data  (rx_byte),
        .crc   (crc)
    );

    frc_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (result_comb),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .free       (in_ready),
        .result_out (result_q)
    );

    assign byte_invalid  = result_q.byte_invalid;
    assign payload_valid = result_q.payload_valid;
    assign payload_byte  = result_q.payload_byte;
    assign frame_event   = result_q.frame_event;
    assign frame_length  = result_q.frame_length;

endmodule

// File: hw/rtl/frc_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module frc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        byte_invalid,
    input logic        payload_valid,
    input logic [7:0]  payload_byte,
    input logic [2:0]  frame_event,
    input logic [15:0] frame_length
);
    import frc_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_event) &&
        $stable(frame_length) && $stable(payload_byte))
        else $error("result changed while stalled");

    // empty result register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // an accepted word always yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    // idle reject and payload are exclusive, and a reject carries no event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_invalid |-> !payload_valid && frame_event == EV_NONE)
        else $error("invalid byte flagged with payload or event");

    // zero-length abort reports zero length; no event means no length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_event == EV_ZERO || frame_event == EV_NONE) |->
        frame_length == 16'd0)
        else $error("frame length set without a frame event");

endmodule

bind frame_receiver_crc32 frc_checker u_frc_checker (.*);

// File: tb/frame_receiver_crc32_tb.sv
// Self-checking testbench for the frame receiver: framed byte streams with a predicting scoreboard.
`timescale 1ns / 100ps

module frame_receiver_crc32_tb;
    import frc_pkg::*;

    localparam int LENGTH_BYTES     = 2;
    localparam int CHECK_BYTES      = 4;
    localparam int LATENCY          = 1;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;

    typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_CHECKSUM, FLAW_CUT} frame_flaw_t;

    class frame_scoreboard;
        int          errors;
        logic [15:0] capacity;
        result_t     expected_q[$];
        phase_t      phase;
        logic [7:0]  kind;
        logic [15:0] plen;
        logic [15:0] pcount;
        logic [31:0] acc;
        logic [2:0]  fcount;
        logic [7:0]  hxor;
        logic [31:0] crc;

        function new();
            errors   = 0;
            capacity = CAPACITY_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            phase  = PH_IDLE;
            kind   = KIND_NONE;
            plen   = '0;
            pcount = '0;
            acc    = '0;
            fcount = '0;
            hxor   = '0;
            crc    = '0;
        endfunction

        function logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] b);
            logic [31:0] v;
            v = c ^ {24'h0, b};
            repeat (8) v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'h0);
            return v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(input logic [7:0] b);
            result_t r;
            r.byte_invalid  = 1'b0;
            r.payload_valid = 1'b0;
            r.payload_byte  = '0;
            r.frame_event   = EV_NONE;
            r.frame_length  = '0;
            case (phase)
                PH_KIND:
                begin
                    kind   = b;
                    hxor  ^= b;
                    acc    = '0;
                    fcount = '0;
                    phase  = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    acc    |= 32'(b) << {fcount[0], 3'b000};
                    fcount  = fcount + 3'd1;
                    hxor   ^= b;
                    if (fcount == LENGTH_BYTES)
                    begin
                        plen = acc[15:0];
                        if (plen == 16'd0)
                        begin
                            r.frame_event = EV_ZERO;
                            clear_frame();
                        end
                        else
                            phase = PH_HDRXOR;
                    end
                end
                PH_HDRXOR:
                begin
                    if (hxor != b)
                    begin
                        r.frame_event  = EV_XOR;
                        r.frame_length = plen;
                        clear_frame();
                    end
                    else if (plen > capacity)
                    begin
                        r.frame_event  = EV_LONG;
                        r.frame_length = plen;
                        clear_frame();
                    end
                    else
                    begin
                        phase = PH_PAYLOAD;
                        if (kind == KIND_CRC32)
                            crc = CRC_PRESET;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    if (kind == KIND_CRC32)
                        crc = crc32_advance(crc, b);
                    pcount = pcount + 16'd1;
                    if (pcount == plen)
                    begin
                        if (kind != KIND_NONE)
                        begin
                            phase  = PH_CHECK;
                            acc    = '0;
                            fcount = '0;
                        end
                        else
                        begin
                            r.frame_event  = EV_GOOD;
                            r.frame_length = plen;
                            clear_frame();
                        end
                    end
                end
                PH_CHECK:
                begin
                    acc    |= 32'(b) << {fcount[1:0], 3'b000};
                    fcount  = fcount + 3'd1;
                    if (fcount == CHECK_BYTES)
                    begin
                        if (kind != KIND_CRC32 || (crc ^ CRC_FINAL_XOR) == acc)
                            r.frame_event = EV_GOOD;
                        else
                            r.frame_event = EV_CRC;
                        r.frame_length = plen;
                        clear_frame();
                    end
                end
                default:
                begin
                    clear_frame();
                    if (b == START_BYTE)
                    begin
                        hxor  = b;
                        phase = PH_KIND;
                    end
                    else
                        r.byte_invalid = 1'b1;
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word 0x%h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("byte_invalid", 16'(want.byte_invalid), 16'(got.byte_invalid));
            compare_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
            compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
            compare_field("frame_event", 16'(want.frame_event), 16'(got.frame_event));
            compare_field("frame_length", want.frame_length, got.frame_length);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        byte_invalid;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_event;
    logic [15:0] frame_length;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    frame_scoreboard sb = new();
    int words_sent    = 0;
    int cycles        = 0;
    bit tx_gaps       = 1'b1;
    bit rx_gaps       = 1'b1;
    bit long_hold_req = 1'b0;

    frame_receiver_crc32 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_invalid  (byte_invalid),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .frame_event   (frame_event),
        .frame_length  (frame_length),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("frame_receiver_crc32 regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n && in_valid && in_ready)
            sb.note_input(rx_byte);
        if (rst_n && out_valid && out_ready)
        begin
            got.byte_invalid  = byte_invalid;
            got.payload_valid = payload_valid;
            got.payload_byte  = payload_byte;
            got.frame_event   = event_t'(frame_event);
            got.frame_length  = frame_length;
            sb.check_result(got);
        end
    end

    // mostly back-to-back, sometimes a short pause, rarely a long pause
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin : receiver
        int n;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(3) == 0)
            begin
                n = idle_length() + 1;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
        gap = tx_gaps ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.capacity = value;
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] kind, input logic [15:0] len,
                              input frame_flaw_t flaw);
        logic [7:0]  q[$];
        logic [7:0]  hdr_xor;
        logic [7:0]  d;
        logic [31:0] crc;
        int          cut;
        hdr_xor = START_BYTE ^ kind ^ len[7:0] ^ len[15:8];
        if (flaw == FLAW_HEADER)
            hdr_xor ^= 8'(1 << $urandom_range(7));
        q.push_back(START_BYTE);
        q.push_back(kind);
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
        if (len != 16'd0)
            q.push_back(hdr_xor);
        if (len != 16'd0 && flaw != FLAW_HEADER && len <= sb.capacity)
        begin
            crc = CRC_PRESET;
            for (int i = 0; i < len; i++)
            begin
                d = 8'($urandom_range(255));
                q.push_back(d);
                crc = sb.crc32_advance(crc, d);
            end
            if (kind != KIND_NONE)
            begin
                crc ^= CRC_FINAL_XOR;
                if (kind != KIND_CRC32)
                    crc = $urandom;
                if (flaw == FLAW_CHECKSUM)
                    crc ^= 32'(1) << $urandom_range(31);
                for (int i = 0; i < CHECK_BYTES; i++)
                    q.push_back(crc[8*i +: 8]);
            end
        end
        if (flaw == FLAW_CUT)
        begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut)
                void'(q.pop_back());
        end
        foreach (q[i])
            send_word(q[i]);
    endtask

    task automatic run_random(input int n_words);
        int          target;
        int          r;
        logic [7:0]  kind;
        logic [15:0] len;
        frame_flaw_t flaw;
        target = words_sent + n_words;
        while (words_sent < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(255)));
                continue;
            end
            r = $urandom_range(99);
            kind = (r < 45) ? KIND_CRC32 : (r < 80) ? KIND_NONE : 8'($urandom_range(255));
            r = $urandom_range(99);
            if (r < 5)
                len = 16'd0;
            else if (r < 17 && sb.capacity != 16'hFFFF)
                len = $urandom_range(1) ? sb.capacity + 16'd1
                                        : 16'($urandom_range(sb.capacity + 1, 65535));
            else if (r < 25 && sb.capacity != 16'd0 && sb.capacity <= 16'd40)
                len = sb.capacity;
            else if (r < 80)
                len = 16'($urandom_range(1, 8));
            else
                len = 16'($urandom_range(9, 40));
            r = $urandom_range(99);
            flaw = (r < 80) ? FLAW_NONE : (r < 87) ? FLAW_HEADER
                 : (r < 94) ? FLAW_CHECKSUM : FLAW_CUT;
            send_frame(kind, len, flaw);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        rx_byte     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(8'h00);
        send_word(8'hFF);
        send_frame(KIND_NONE, 16'd1, FLAW_NONE);
        send_frame(KIND_CRC32, 16'd0, FLAW_NONE);
        send_frame(KIND_CRC32, 16'd2, FLAW_HEADER);
        send_frame(KIND_NONE, 16'hFFFF, FLAW_NONE);
        send_frame(8'hFF, 16'hFFFF, FLAW_HEADER);
        send_frame(KIND_CRC32, 16'd1, FLAW_NONE);
        send_frame(KIND_CRC32, 16'd1, FLAW_CHECKSUM);
        send_frame(8'hA5, 16'd1, FLAW_NONE);

        // long output stall while the sender keeps offering words
        write_capacity(16'hFFFF);
        long_hold_req = 1'b1;
        run_random(85);
        drain();
        run_random(85);

        write_capacity(16'd0);
        run_random(60);

        write_capacity(16'd6);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(170);

        write_capacity(16'd1024);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random(150);

        write_capacity(16'd40);
        tx_gaps = 1'b0;
        run_random(100);

        drain();
        if (sb.errors == 0)
            $display("frame_receiver_crc32 regression: pass");
        else
            $display("frame_receiver_crc32 regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/frc_pkg.sv
hw/rtl/frc_crc.sv
hw/rtl/frc_deframer.sv
hw/rtl/frc_out_reg.sv
hw/rtl/frame_receiver_crc32.sv
hw/rtl/frc_checker.sv
tb/frame_receiver_crc32_tb.sv
